/* design/npld_pkg.sv */
// Shared types and constants of the nearest-pair line distance unit.
// Holds the transaction structs, state and command types and status codes.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package npld_pkg;

   localparam int COORD_WIDTH  = 20;
   localparam int DIST_WIDTH   = 2 * COORD_WIDTH + 4;
   localparam int OUT_WIDTH    = 48;
   localparam int STATUS_WIDTH = 2;
   localparam int KEEP         = 3;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FEW_HITS   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_COINCIDENT = 2'd2;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] hit_x;
      logic signed [COORD_WIDTH-1:0] hit_y;
      logic signed [COORD_WIDTH-1:0] hit_z;
      logic signed [COORD_WIDTH-1:0] query_x;
      logic signed [COORD_WIDTH-1:0] query_y;
      logic signed [COORD_WIDTH-1:0] query_z;
      logic                          last_hit;
   } req_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0]    dist_squared;
      logic [STATUS_WIDTH-1:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HIT_SQ,
      ST_HIT_UPD,
      ST_PRJ_DIFF,
      ST_PRJ_MUL,
      ST_PRJ_SUM,
      ST_PRJ_CHK,
      ST_DIV,
      ST_TAU,
      ST_RES_MUL,
      ST_RES_RND,
      ST_RES_ADD,
      ST_RES_SQ,
      ST_RES_LOAD
   } state_type;

   // One strobe per datapath step.
   typedef struct packed {
      logic capture;
      logic hit_sq;
      logic hit_upd;
      logic prj_diff;
      logic prj_mul;
      logic prj_sum;
      logic prj_chk;
      logic div_step;
      logic tau_make;
      logic res_mul;
      logic res_rnd;
      logic res_add;
      logic res_sq;
      logic res_load;
   } cmd_type;

   typedef struct packed {
      logic last_hit;
   } stat_type;

endpackage

`default_nettype wire

/* design/nearest_pair_line_distance_unit.sv */
// Nearest-pair line distance unit. A hit transaction is taken only once the
// last has passed capture, square, compare and update; the final hit of a set
// goes on through projection, the tau divider (TAU_FRAC_BITS + 3 quotient bits,
// one quotient bit a cycle), rounding and squaring to yield its result.
// A finished result is held in the output register while new hits stream in.
// Synchronous reset clears the sequencer, the result valid and the set state.
`default_nettype none

module nearest_pair_line_distance_unit #(
   parameter int TAU_FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire npld_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output npld_pkg::rsp_type      rsp_payload
);

   // The controller owns sequencing and the handshakes; the datapath owns
   // every arithmetic register. They meet only through these two structs.
   npld_pkg::cmd_type  cmd;
   npld_pkg::stat_type stat;

   // A hit transaction is accepted whenever the sequencer is idle. A result
   // that is still stalled at the output does not block further hits; only
   // the final load of the next result waits for it to be taken.
   npld_ctrl #(
      .TAU_FRAC_BITS (TAU_FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath keeps the two hits nearest the query, then projects the
   // query onto the line through them with tau clamped to [-3, 4] and
   // forms the squared distance to the clamped point. A coincident pair
   // takes tau as zero; missing hits stand at the origin.
   npld_dpath #(
      .TAU_FRAC_BITS (TAU_FRAC_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* design/npld_ctrl.sv */
// Sequencer of the nearest-pair line distance unit.
// Drives the datapath step strobes, the input stall and the result valid.
// Depends on npld_pkg.
`default_nettype none

module npld_ctrl #(
   parameter int TAU_FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire npld_pkg::stat_type stat,
   output npld_pkg::cmd_type       cmd
);

   localparam int DIV_STEPS = TAU_FRAC_BITS + 3;
   localparam int CNT_WIDTH = $clog2(DIV_STEPS);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(DIV_STEPS - 1);

   npld_pkg::state_type  state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= npld_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         npld_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = npld_pkg::ST_HIT_SQ;
            end
         end
         npld_pkg::ST_HIT_SQ: begin
            cmd.hit_sq = 1'b1;
            state_in   = npld_pkg::ST_HIT_UPD;
         end
         npld_pkg::ST_HIT_UPD: begin
            cmd.hit_upd = 1'b1;
            state_in    = stat.last_hit ? npld_pkg::ST_PRJ_DIFF : npld_pkg::ST_IDLE;
         end
         npld_pkg::ST_PRJ_DIFF: begin
            cmd.prj_diff = 1'b1;
            state_in     = npld_pkg::ST_PRJ_MUL;
         end
         npld_pkg::ST_PRJ_MUL: begin
            cmd.prj_mul = 1'b1;
            state_in    = npld_pkg::ST_PRJ_SUM;
         end
         npld_pkg::ST_PRJ_SUM: begin
            cmd.prj_sum = 1'b1;
            state_in    = npld_pkg::ST_PRJ_CHK;
         end
         npld_pkg::ST_PRJ_CHK: begin
            cmd.prj_chk = 1'b1;
            cnt_in      = '0;
            state_in    = npld_pkg::ST_DIV;
         end
         npld_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = npld_pkg::ST_TAU;
            end else begin
               cnt_in = cnt_ff + CNT_WIDTH'(1);
            end
         end
         npld_pkg::ST_TAU: begin
            cmd.tau_make = 1'b1;
            state_in     = npld_pkg::ST_RES_MUL;
         end
         npld_pkg::ST_RES_MUL: begin
            cmd.res_mul = 1'b1;
            state_in    = npld_pkg::ST_RES_RND;
         end
         npld_pkg::ST_RES_RND: begin
            cmd.res_rnd = 1'b1;
            state_in    = npld_pkg::ST_RES_ADD;
         end
         npld_pkg::ST_RES_ADD: begin
            cmd.res_add = 1'b1;
            state_in    = npld_pkg::ST_RES_SQ;
         end
         npld_pkg::ST_RES_SQ: begin
            cmd.res_sq = 1'b1;
            state_in   = npld_pkg::ST_RES_LOAD;
         end
         npld_pkg::ST_RES_LOAD: begin
            // Wait here only while an earlier result is still held.
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.res_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = npld_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = npld_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* design/npld_dpath.sv */
// Datapath of the nearest-pair line distance unit: hit tracking, projection,
// a bit-serial divider for tau and the final squared distance.
// Depends on npld_pkg; stepped by the strobes of npld_ctrl.
`default_nettype none

module npld_dpath #(
   parameter int TAU_FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire npld_pkg::req_type req_payload,
   input  wire npld_pkg::cmd_type cmd,
   output npld_pkg::stat_type     stat,
   output npld_pkg::rsp_type      rsp_payload
);

   localparam int CW  = npld_pkg::COORD_WIDTH;
   localparam int DW  = CW + 1;              // coordinate difference
   localparam int PW  = 2 * DW;              // product of two differences
   localparam int SQW = 2 * CW + 1;          // square of a difference
   localparam int AW  = 2 * CW + 2;          // sum of three such products
   localparam int RW  = AW + 2;              // divider remainder
   localparam int DSW = npld_pkg::DIST_WIDTH;
   localparam int QW  = TAU_FRAC_BITS + 3;   // raw quotient, one extra rounding bit
   localparam int TW  = TAU_FRAC_BITS + 4;   // signed tau
   localparam int MW  = TW + DW;             // tau times a difference
   localparam int PMW = DW + 2;              // rounded product magnitude
   localparam int CRW = DW + 3;              // component of the final vector
   localparam int OW  = npld_pkg::OUT_WIDTH;
   localparam int SW  = npld_pkg::STATUS_WIDTH;
   localparam logic [MW-1:0] ROUND_HALF = MW'(1) << (TAU_FRAC_BITS - 1);

   // Transaction capture
   logic signed [CW-1:0] hit_ff [3];
   logic                 last_ff;
   logic signed [CW-1:0] hit_req [3];
   logic signed [CW-1:0] qry_req [3];

   // Set state
   logic signed [CW-1:0] query_ff   [3];
   logic signed [CW-1:0] nearest_ff [3];
   logic signed [CW-1:0] second_ff  [3];
   logic [DSW-1:0]       ndist_ff;
   logic [DSW-1:0]       sdist_ff;
   logic [1:0]           hits_ff;
   logic                 in_set_ff;

   // Hit distance
   logic signed [DW-1:0] hq_diff [3];
   logic signed [PW-1:0] hq_prod [3];
   logic [SQW-1:0]       hsq_ff  [3];
   logic [AW-1:0]        hdist_sum;
   logic [DSW-1:0]       hdist;

   // Projection
   logic signed [DW-1:0] d_ff  [3];
   logic signed [DW-1:0] e_ff  [3];
   logic signed [PW-1:0] dd_ff [3];
   logic signed [PW-1:0] de_ff [3];
   logic                 coinc;
   logic                 coinc_ff;
   logic [SW-1:0]        status_ff;
   logic signed [AW:0]   aa_sum;
   logic signed [AW:0]   ab_sum;
   logic [AW-1:0]        aa_ff;
   logic [AW-1:0]        mag_ff;
   logic                 neg_ff;
   logic [2:0]           lim;
   logic [RW-1:0]        lim_aa;
   logic                 over_ff;

   // Divider
   logic [RW-1:0]        rem_ff;
   logic [QW-1:0]        quo_ff;
   logic [RW:0]          rem_sh;
   logic [RW:0]          div_den;

   // Tau and result
   logic [QW:0]          q_inc;
   logic [QW-1:0]        q_rnd;
   logic [QW-1:0]        q_lim;
   logic [QW-1:0]        q_sel;
   logic signed [TW-1:0] tau_ff;
   logic signed [MW-1:0] p_ff  [3];
   logic [MW-1:0]        p_mag [3];
   logic [MW-1:0]        p_rnd [3];
   logic [PMW-1:0]       pm_ff [3];
   logic                 pneg_ff [3];
   logic signed [CRW-1:0] c_ff [3];
   logic signed [CRW-1:0] pm_s [3];
   logic signed [CRW-1:0] e_x  [3];
   logic signed [2*CRW-1:0] c_prod [3];
   logic [OW-1:0]        csq_ff [3];
   npld_pkg::rsp_type    rsp_ff;

   assign hit_req[0] = req_payload.hit_x;
   assign hit_req[1] = req_payload.hit_y;
   assign hit_req[2] = req_payload.hit_z;
   assign qry_req[0] = req_payload.query_x;
   assign qry_req[1] = req_payload.query_y;
   assign qry_req[2] = req_payload.query_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hq_diff[i] = DW'(query_ff[i]) - DW'(hit_ff[i]);
         hq_prod[i] = hq_diff[i] * hq_diff[i];
      end
      hdist_sum = AW'(hsq_ff[0]) + AW'(hsq_ff[1]) + AW'(hsq_ff[2]);
      hdist     = DSW'(hdist_sum);
      coinc     = (nearest_ff[0] == second_ff[0]) && (nearest_ff[1] == second_ff[1])
                  && (nearest_ff[2] == second_ff[2]);
   end

   // Set state: query, the two nearest hits and their distances.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            query_ff[i]   <= '0;
            nearest_ff[i] <= '0;
            second_ff[i]  <= '0;
         end
         ndist_ff  <= '1;
         sdist_ff  <= '1;
         hits_ff   <= 2'd0;
         in_set_ff <= 1'b0;
      end else begin
         if (cmd.capture && !in_set_ff) begin
            for (int i = 0; i < 3; i++) begin
               query_ff[i] <= qry_req[i];
            end
            in_set_ff <= 1'b1;
         end
         if (cmd.hit_upd) begin
            if (hdist < ndist_ff) begin
               for (int i = 0; i < 3; i++) begin
                  second_ff[i]  <= nearest_ff[i];
                  nearest_ff[i] <= hit_ff[i];
               end
               sdist_ff <= ndist_ff;
               ndist_ff <= hdist;
            end else if (hdist < sdist_ff) begin
               for (int i = 0; i < 3; i++) begin
                  second_ff[i] <= hit_ff[i];
               end
               sdist_ff <= hdist;
            end
            if (hits_ff != 2'd2) begin
               hits_ff <= hits_ff + 2'd1;
            end
         end
         if (cmd.res_load) begin
            for (int i = 0; i < 3; i++) begin
               nearest_ff[i] <= '0;
               second_ff[i]  <= '0;
            end
            ndist_ff  <= '1;
            sdist_ff  <= '1;
            hits_ff   <= 2'd0;
            in_set_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      aa_sum  = (AW + 1)'(dd_ff[0]) + (AW + 1)'(dd_ff[1]) + (AW + 1)'(dd_ff[2]);
      ab_sum  = (AW + 1)'(de_ff[0]) + (AW + 1)'(de_ff[1]) + (AW + 1)'(de_ff[2]);
      lim     = neg_ff ? 3'(npld_pkg::KEEP) : 3'(npld_pkg::KEEP + 1);
      lim_aa  = neg_ff ? RW'(aa_ff) * RW'(npld_pkg::KEEP)
                       : RW'(aa_ff) * RW'(npld_pkg::KEEP + 1);
      rem_sh  = {rem_ff, 1'b0};
      div_den = (RW + 1)'(aa_ff) << 2;
      q_inc   = (QW + 1)'(quo_ff) + (QW + 1)'(1);
      q_rnd   = q_inc[QW:1];
      q_lim   = QW'(lim) << TAU_FRAC_BITS;
      q_sel   = (over_ff || (q_rnd > q_lim)) ? q_lim : q_rnd;
      for (int i = 0; i < 3; i++) begin
         p_mag[i]  = (p_ff[i] < 0) ? MW'(-p_ff[i]) : MW'(p_ff[i]);
         p_rnd[i]  = p_mag[i] + ROUND_HALF;
         e_x[i]    = CRW'(e_ff[i]);
         pm_s[i]   = $signed(CRW'(pm_ff[i]));
         c_prod[i] = c_ff[i] * c_ff[i];
      end
   end

   // Step registers; none of them needs a reset.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int i = 0; i < 3; i++) begin
            hit_ff[i] <= hit_req[i];
         end
         last_ff <= req_payload.last_hit;
      end
      if (cmd.hit_sq) begin
         for (int i = 0; i < 3; i++) begin
            hsq_ff[i] <= hq_prod[i][SQW-1:0];
         end
      end
      if (cmd.prj_diff) begin
         for (int i = 0; i < 3; i++) begin
            d_ff[i] <= DW'(nearest_ff[i]) - DW'(second_ff[i]);
            e_ff[i] <= DW'(second_ff[i]) - DW'(query_ff[i]);
         end
         coinc_ff <= coinc;
         if (hits_ff != 2'd2) begin
            status_ff <= npld_pkg::STATUS_FEW_HITS;
         end else if (coinc) begin
            status_ff <= npld_pkg::STATUS_COINCIDENT;
         end else begin
            status_ff <= npld_pkg::STATUS_OK;
         end
      end
      if (cmd.prj_mul) begin
         for (int i = 0; i < 3; i++) begin
            dd_ff[i] <= d_ff[i] * d_ff[i];
            de_ff[i] <= d_ff[i] * e_ff[i];
         end
      end
      if (cmd.prj_sum) begin
         aa_ff  <= aa_sum[AW-1:0];
         neg_ff <= ab_sum > 0;
         mag_ff <= (ab_sum < 0) ? AW'(-ab_sum) : AW'(ab_sum);
      end
      if (cmd.prj_chk) begin
         over_ff <= RW'(mag_ff) >= lim_aa;
         rem_ff  <= RW'(mag_ff);
         quo_ff  <= '0;
      end
      if (cmd.div_step) begin
         // The divisor is aa * 4; the remainder starts as the unscaled magnitude.
         if (rem_sh >= div_den) begin
            rem_ff <= RW'(rem_sh - div_den);
            quo_ff <= {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[RW-1:0];
            quo_ff <= {quo_ff[QW-2:0], 1'b0};
         end
      end
      if (cmd.tau_make) begin
         if (coinc_ff) begin
            tau_ff <= '0;
         end else if (neg_ff) begin
            tau_ff <= -$signed(TW'(q_sel));
         end else begin
            tau_ff <= $signed(TW'(q_sel));
         end
      end
      if (cmd.res_mul) begin
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= tau_ff * d_ff[i];
         end
      end
      if (cmd.res_rnd) begin
         for (int i = 0; i < 3; i++) begin
            pm_ff[i]   <= PMW'(p_rnd[i] >> TAU_FRAC_BITS);
            pneg_ff[i] <= p_ff[i] < 0;
         end
      end
      if (cmd.res_add) begin
         for (int i = 0; i < 3; i++) begin
            c_ff[i] <= pneg_ff[i] ? (e_x[i] - pm_s[i]) : (e_x[i] + pm_s[i]);
         end
      end
      if (cmd.res_sq) begin
         for (int i = 0; i < 3; i++) begin
            csq_ff[i] <= c_prod[i][OW-1:0];
         end
      end
      if (cmd.res_load) begin
         rsp_ff.dist_squared <= csq_ff[0] + csq_ff[1] + csq_ff[2];
         rsp_ff.status       <= status_ff;
      end
   end

   assign stat.last_hit = last_ff;
   assign rsp_payload   = rsp_ff;

endmodule

`default_nettype wire
